/* hdl/trial_division_factorizer_unit_assert.svh */
// Assertion macros for the trial division factorizer.
// Included by the top level; depends on nothing else.
`ifndef TRIAL_DIVISION_FACTORIZER_UNIT_ASSERT_SVH
`define TRIAL_DIVISION_FACTORIZER_UNIT_ASSERT_SVH

`define TDF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tdf check failed: same cycle");

`define TDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tdf check failed: next cycle");

`endif

/* hdl/tdf_pkg.sv */
// Shared types and constants of the trial division factorizer.
// Used by tdf_out and the top level; depends on nothing.
package tdf_pkg;

	localparam int PRIME_W = 31;
	localparam int POWER_W = 5;
	localparam int CNT_W   = 4;

	localparam logic [POWER_W-1:0] POWER_MAX   = 5'd31;
	localparam logic [CNT_W-1:0]   MAX_RESULTS = 4'd15;

	typedef struct packed {
		logic               valid;
		logic [PRIME_W-1:0] prime;
		logic [POWER_W-1:0] power;
	} factor_t;

	typedef struct packed {
		logic done;
		logic positive;
	} finish_t;

endpackage

/* hdl/trial_division_factorizer_unit.sv */
// Top level of the trial division factorizer: sequencer around one shared divider.
// Depends on tdf_pkg, tdf_div, tdf_out and trial_division_factorizer_unit_assert.svh.
//
//   port group    | direction | transfer
//   start / value | in        | start high while busy low
//   valid / prime, power, no_factors, is_prime, last | out | one cycle per valid pulse
//
// Each division runs through S_START and S_WAIT on the shared radix-2 divider, each
// candidate passed adds S_NEXT, and S_FINAL and S_FINISH close the item. Candidates are
// 2, 3, 5, 7, 11 and so on up to the square root of what is left, plus one division per
// repeated factor. Magnitudes 0 and 1 go straight to S_FINISH and keep busy high for
// one cycle. A result is held until the next factor is found; the last one comes in the
// cycle after busy falls.
// Reset clears the sequencer and all strobes. The receiver cannot stall.
`include "trial_division_factorizer_unit_assert.svh"

module trial_division_factorizer_unit import tdf_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] value,
	output logic                         valid,
	output logic [PRIME_W-1:0]           prime,
	output logic [POWER_W-1:0]           power,
	output logic                         no_factors,
	output logic                         is_prime,
	output logic                         last
);

	localparam int W = DATA_WIDTH;

	localparam logic [W-1:0] CAND_TWO   = W'(2);
	localparam logic [W-1:0] CAND_THREE = W'(3);
	localparam logic [W-1:0] CAND_FIVE  = W'(5);
	localparam logic [W-1:0] STEP_SHORT = W'(2);
	localparam logic [W-1:0] STEP_LONG  = W'(4);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_WAIT,
		S_NEXT,
		S_FINAL,
		S_FINISH
	} state_t;

	state_t             state_q;
	logic [W-1:0]       rem_q;
	logic [W-1:0]       cand_q;
	logic [POWER_W-1:0] exp_q;
	logic               first_q;
	logic               wheel_q;
	logic               step2_q;
	logic               positive_q;
	factor_t            found_q;
	finish_t            finish_q;

	logic [W-1:0]       val_u;
	logic [W-1:0]       mag;
	logic               mag_small;
	logic [W-1:0]       emit_val;
	logic [PRIME_W-1:0] emit_prime;

	logic               div_go;
	logic               div_done;
	logic [W-1:0]       div_quo;
	logic [W-1:0]       div_rem;

	always_comb begin
		val_u     = value;
		mag       = val_u[W-1] ? (W'(0) - val_u) : val_u;
		mag_small = (mag[W-1:1] == '0);
		emit_val  = (state_q == S_FINAL) ? rem_q : cand_q;
		div_go    = (state_q == S_START);
	end

	generate
		if (W >= PRIME_W) begin : g_prime_trunc
			assign emit_prime = emit_val[PRIME_W-1:0];
		end else begin : g_prime_ext
			assign emit_prime = {{(PRIME_W - W){1'b0}}, emit_val};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rem_q      <= '0;
			cand_q     <= CAND_FIVE;
			exp_q      <= '0;
			first_q    <= 1'b0;
			wheel_q    <= 1'b0;
			step2_q    <= 1'b1;
			positive_q <= 1'b0;
			found_q    <= '0;
			finish_q   <= '0;
		end else begin
			found_q.valid <= 1'b0;
			finish_q.done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						positive_q <= !val_u[W-1] && (val_u != '0);
						rem_q      <= mag;
						cand_q     <= CAND_TWO;
						exp_q      <= '0;
						first_q    <= 1'b1;
						wheel_q    <= 1'b0;
						step2_q    <= 1'b1;
						state_q    <= mag_small ? S_FINISH : S_START;
					end
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_done) begin
						priority if (first_q && wheel_q && (cand_q > div_quo)) begin
							state_q <= S_FINAL;
						end else if (div_rem == '0) begin
							rem_q   <= div_quo;
							exp_q   <= (exp_q == POWER_MAX) ? POWER_MAX : exp_q + POWER_W'(1);
							first_q <= 1'b0;
							state_q <= S_START;
						end else begin
							state_q <= S_NEXT;
						end
					end
				end
				S_NEXT: begin
					found_q.valid <= (exp_q != '0);
					found_q.prime <= emit_prime;
					found_q.power <= exp_q;
					if (!wheel_q) begin
						if (cand_q == CAND_TWO) begin
							cand_q <= CAND_THREE;
						end else begin
							cand_q  <= CAND_FIVE;
							wheel_q <= 1'b1;
							step2_q <= 1'b1;
						end
					end else begin
						cand_q  <= cand_q + (step2_q ? STEP_SHORT : STEP_LONG);
						step2_q <= !step2_q;
					end
					exp_q   <= '0;
					first_q <= 1'b1;
					state_q <= S_START;
				end
				S_FINAL: begin
					found_q.valid <= (rem_q[W-1:1] != '0);
					found_q.prime <= emit_prime;
					found_q.power <= POWER_W'(1);
					state_q       <= S_FINISH;
				end
				S_FINISH: begin
					finish_q.done     <= 1'b1;
					finish_q.positive <= positive_q;
					state_q           <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	tdf_div #(
		.W(W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (rem_q),
		.divisor  (cand_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	tdf_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.found     (found_q),
		.finish    (finish_q),
		.valid     (valid),
		.prime     (prime),
		.power     (power),
		.no_factors(no_factors),
		.is_prime  (is_prime),
		.last      (last)
	);

	`TDF_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`TDF_ASSERT_IMPLY(a_div_in_wait, clk, arst_n, div_done, state_q == S_WAIT)
	`TDF_ASSERT_IMPLY(a_empty_result, clk, arst_n, valid && no_factors,
		last && (prime == '0) && (power == '0) && !is_prime)
	`TDF_ASSERT_IMPLY(a_prime_single, clk, arst_n, valid && is_prime, last && (power == 5'd1))

endmodule

/* hdl/tdf_div.sv */
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Standalone; used by the top level of the trial division factorizer.
module tdf_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;

	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         fits;

	always_comb begin
		trial = {rem_q, quo_q[W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = !diff[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
				quo_q  <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
				quo_q <= {quo_q[W-2:0], fits};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* hdl/tdf_out.sv */
// Result stage: holds one found factor back until the next one or the end,
// so last and is_prime are known. Depends on tdf_pkg.
module tdf_out import tdf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  factor_t            found,
	input  finish_t            finish,
	output logic               valid,
	output logic [PRIME_W-1:0] prime,
	output logic [POWER_W-1:0] power,
	output logic               no_factors,
	output logic               is_prime,
	output logic               last
);

	logic               pend_q;
	logic [PRIME_W-1:0] pend_prime_q;
	logic [POWER_W-1:0] pend_power_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               valid_q;
	logic [PRIME_W-1:0] prime_q;
	logic [POWER_W-1:0] power_q;
	logic               no_factors_q;
	logic               is_prime_q;
	logic               last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= 1'b0;
			pend_prime_q <= '0;
			pend_power_q <= '0;
			cnt_q        <= '0;
			valid_q      <= 1'b0;
			prime_q      <= '0;
			power_q      <= '0;
			no_factors_q <= 1'b0;
			is_prime_q   <= 1'b0;
			last_q       <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			if (finish.done) begin
				valid_q <= 1'b1;
				last_q  <= 1'b1;
				if (pend_q) begin
					prime_q      <= pend_prime_q;
					power_q      <= pend_power_q;
					no_factors_q <= 1'b0;
					is_prime_q   <= finish.positive && (cnt_q == CNT_W'(1)) &&
					                (pend_power_q == POWER_W'(1));
				end else begin
					prime_q      <= '0;
					power_q      <= '0;
					no_factors_q <= 1'b1;
					is_prime_q   <= 1'b0;
				end
				pend_q <= 1'b0;
				cnt_q  <= '0;
			end else if (found.valid && (cnt_q != MAX_RESULTS)) begin
				if (pend_q) begin
					valid_q      <= 1'b1;
					prime_q      <= pend_prime_q;
					power_q      <= pend_power_q;
					no_factors_q <= 1'b0;
					is_prime_q   <= 1'b0;
					last_q       <= 1'b0;
				end
				pend_q       <= 1'b1;
				pend_prime_q <= found.prime;
				pend_power_q <= found.power;
				cnt_q        <= cnt_q + CNT_W'(1);
			end
		end
	end

	assign valid      = valid_q;
	assign prime      = prime_q;
	assign power      = power_q;
	assign no_factors = no_factors_q;
	assign is_prime   = is_prime_q;
	assign last       = last_q;

endmodule
